@@ rtl/core/hpi_pkg.sv @@
// shared types, constants and the 8-tap half-pel filter function
`default_nettype none
package hpi_pkg;

  localparam int PIX_W          = 8;
  localparam int TAPS           = 8;
  localparam int HIST           = 7;
  localparam int ROW_WIDTH_W    = 13;
  localparam int MAX_ROW_WIDTH  = 4096;
  localparam int ROW_WIDTH_RST  = 64;
  localparam int PAD_LEAD       = 7;
  localparam int SUM_W          = 16;
  localparam int RND            = 16;
  localparam int SHIFT          = 5;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [TAPS-1:0][PIX_W-1:0] pix_win_t;

  // symmetric taps -1,3,-7,21,21,-7,3,-1 with rounding and clamp to 0..255
  function automatic pix_t filt8(input pix_win_t w);
    logic [PIX_W:0]          a;
    logic [PIX_W:0]          b;
    logic [PIX_W:0]          c;
    logic [PIX_W:0]          d;
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-SHIFT-2:0]  t;
    pix_t                    r;
    a = {1'b0, w[3]} + {1'b0, w[4]};
    b = {1'b0, w[2]} + {1'b0, w[5]};
    c = {1'b0, w[1]} + {1'b0, w[6]};
    d = {1'b0, w[0]} + {1'b0, w[7]};
    s = $signed(SUM_W'(a) * SUM_W'(21)) - $signed(SUM_W'(b) * SUM_W'(7))
      + $signed(SUM_W'(c) * SUM_W'(3)) - $signed(SUM_W'(d)) + $signed(SUM_W'(RND));
    t = s[SUM_W-2:SHIFT];
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (t > (SUM_W-SHIFT-1)'(255)) begin
      r = '1;
    end else begin
      r = t[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage : hpi_pkg
`default_nettype wire

@@ rtl/core/half_pel_interpolation_filter.sv @@
// half-pel interpolation filter: vertical, horizontal and diagonal 8-tap half-pel values
//
// usage:
// - input channel (in_valid / in_stall): one column of eight vertically adjacent
//   pixels per transaction, rows y-3 .. y+4; a row is fed from padded column -3
//   to column row_width+4, i.e. row_width+8 transactions per row
// - output channel (out_valid / out_stall): one transaction per real column
//   0 .. row_width-1 with half_h, half_v, half_c and row_end on the last column;
//   the seven leading padding columns and the trailing one give no output
// - cfg_we / cfg_row_width: row width, written while the block is idle; 0 acts
//   as 1, values above MAX_ROW_WIDTH act as MAX_ROW_WIDTH
// - each accepted column passes through the input register, the vertical filter
//   register and the output register
// - throughput: one column per clock while out_stall is low; each stage advances as soon
//   as the one after it is empty or moving, so bubbles between transactions cost nothing
// - out_stall holds the output register; stages behind it fill up and then
//   in_stall rises
// - reset (rst_n low, synchronous) empties the pipeline, clears the tap windows
//   and the column position, and sets the row width to 64
`default_nettype none
module half_pel_interpolation_filter #(
  parameter int MAX_ROW_WIDTH = hpi_pkg::MAX_ROW_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [hpi_pkg::ROW_WIDTH_W-1:0]  cfg_row_width,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire hpi_pkg::pix_t                    in_pix_up3,
  input  wire hpi_pkg::pix_t                    in_pix_up2,
  input  wire hpi_pkg::pix_t                    in_pix_up1,
  input  wire hpi_pkg::pix_t                    in_pix_here,
  input  wire hpi_pkg::pix_t                    in_pix_dn1,
  input  wire hpi_pkg::pix_t                    in_pix_dn2,
  input  wire hpi_pkg::pix_t                    in_pix_dn3,
  input  wire hpi_pkg::pix_t                    in_pix_dn4,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output hpi_pkg::pix_t                         out_half_h,
  output hpi_pkg::pix_t                         out_half_v,
  output hpi_pkg::pix_t                         out_half_c,
  output logic                                  out_row_end
);
  import hpi_pkg::*;

  localparam int CW = $clog2(MAX_ROW_WIDTH + PAD_LEAD + 1);
  localparam int EW = (CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W;
  localparam int WIDTH_RST = (ROW_WIDTH_RST < MAX_ROW_WIDTH) ? ROW_WIDTH_RST : MAX_ROW_WIDTH;

  // handshake
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_rdy, s2_rdy, s1_rdy, s1_go, s2_go, in_go;

  assign out_rdy  = !out_v_r || !out_stall;
  assign s2_go    = s2_v_r && out_rdy;
  assign s2_rdy   = !s2_v_r || out_rdy;
  assign s1_go    = s1_v_r && s2_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_stall = !s1_rdy;
  assign in_go    = in_valid && s1_rdy;

  // stage 1: input column
  pix_win_t col_r;
  // stage 2: vertical result and center pixel
  pix_t     vert_r, ctr_r;
  // tap history and row position
  pix_t     ctr_taps_r [HIST];
  pix_t     vert_taps_r[HIST];
  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [CW-1:0] eff_w_r, eff_w_nxt;
  // result register
  pix_t     half_h_r, half_v_r, half_c_r;
  logic     row_end_r;

  pix_win_t cw, vw;
  pix_t     vert_nxt;
  logic [CW-1:0] last_pos;
  logic     emit;
  logic [EW-1:0] cfg_ext;

  assign vert_nxt = filt8(col_r);

  always_comb begin
    for (int i = 0; i < HIST; i++) begin
      cw[i] = ctr_taps_r[i];
      vw[i] = vert_taps_r[i];
    end
    cw[HIST] = ctr_r;
    vw[HIST] = vert_r;
  end

  assign last_pos = eff_w_r + CW'(PAD_LEAD - 1);
  assign emit     = (col_cnt_r >= CW'(PAD_LEAD)) && (col_cnt_r <= last_pos);

  always_comb begin
    if (col_cnt_r > last_pos) begin
      col_cnt_nxt = '0;
    end else begin
      col_cnt_nxt = col_cnt_r + CW'(1);
    end
  end

  // width clamped once at write time
  assign cfg_ext = EW'(cfg_row_width);
  always_comb begin
    if (cfg_ext == '0) begin
      eff_w_nxt = CW'(1);
    end else if (cfg_ext > EW'(MAX_ROW_WIDTH)) begin
      eff_w_nxt = CW'(MAX_ROW_WIDTH);
    end else begin
      eff_w_nxt = cfg_ext[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      col_cnt_r <= '0;
      eff_w_r   <= CW'(WIDTH_RST);
      for (int i = 0; i < HIST; i++) begin
        ctr_taps_r[i]  <= '0;
        vert_taps_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        eff_w_r <= eff_w_nxt;
      end
      if (s1_rdy) begin
        s1_v_r <= in_valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (out_rdy) begin
        out_v_r <= s2_v_r && emit;
      end
      if (s2_go) begin
        col_cnt_r <= col_cnt_nxt;
        for (int i = 0; i < HIST; i++) begin
          ctr_taps_r[i]  <= cw[i+1];
          vert_taps_r[i] <= vw[i+1];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      col_r <= {in_pix_dn4, in_pix_dn3, in_pix_dn2, in_pix_dn1,
                in_pix_here, in_pix_up1, in_pix_up2, in_pix_up3};
    end
    if (s1_go) begin
      vert_r <= vert_nxt;
      ctr_r  <= col_r[3];
    end
    if (s2_go && emit) begin
      half_h_r  <= filt8(cw);
      half_v_r  <= vw[3];
      half_c_r  <= filt8(vw);
      row_end_r <= (col_cnt_r == last_pos);
    end
  end

  assign out_valid   = out_v_r;
  assign out_half_h  = half_h_r;
  assign out_half_v  = half_v_r;
  assign out_half_c  = half_c_r;
  assign out_row_end = row_end_r;

endmodule : half_pel_interpolation_filter
`default_nettype wire

@@ verif/tb.sv @@
// testbench for half_pel_interpolation_filter: random column streams checked against a scoreboard
`timescale 1ns / 1ps

module tb;
  import hpi_pkg::*;

  typedef pix_t column_t[TAPS];

  typedef struct packed {
    pix_t half_h;
    pix_t half_v;
    pix_t half_c;
    logic row_end;
  } half_pel_t;

  class half_pel_scoreboard;
    pix_t            center_hist[HIST];
    pix_t            vert_hist[HIST];
    int unsigned     col_pos;
    logic [12:0]     width_reg;
    half_pel_t       pending[$];
    int unsigned     errors;
    int unsigned     results_seen;
    int unsigned     row_ends_seen;

    function new();
      foreach (center_hist[i]) center_hist[i] = '0;
      foreach (vert_hist[i]) vert_hist[i] = '0;
      col_pos = 0;
      width_reg = 13'(ROW_WIDTH_RST);
      errors = 0;
      results_seen = 0;
      row_ends_seen = 0;
    endfunction

    function void set_width(logic [12:0] value);
      width_reg = value;
    endfunction

    function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
      return width_reg;
    endfunction

    // symmetric 8-tap half-pel kernel, rounded and clamped to a pixel
    function pix_t half_pel(column_t w);
      int acc;
      acc = 21 * (int'(w[3]) + int'(w[4])) - 7 * (int'(w[2]) + int'(w[5]))
          + 3 * (int'(w[1]) + int'(w[6])) - (int'(w[0]) + int'(w[7])) + RND;
      if (acc < 0) return '0;
      acc = acc >>> SHIFT;
      if (acc > 255) return '1;
      return pix_t'(acc);
    endfunction

    function void note_column(column_t col);
      column_t     cwin;
      column_t     vwin;
      half_pel_t   res;
      int unsigned w;
      int unsigned pos;
      w = active_width();
      pos = col_pos;
      for (int i = 0; i < HIST; i++) begin
        cwin[i] = center_hist[i];
        vwin[i] = vert_hist[i];
      end
      cwin[HIST] = col[3];
      vwin[HIST] = half_pel(col);
      if (pos >= PAD_LEAD && pos <= w + 6) begin
        res.half_h = half_pel(cwin);
        res.half_v = vwin[3];
        res.half_c = half_pel(vwin);
        res.row_end = (pos == w + 6);
        pending.push_back(res);
      end
      for (int i = 0; i < HIST; i++) begin
        center_hist[i] = cwin[i+1];
        vert_hist[i] = vwin[i+1];
      end
      col_pos = (pos >= w + 7) ? 0 : pos + 1;
    endfunction

    function void check_result(half_pel_t got);
      half_pel_t want;
      results_seen++;
      if (got.row_end) row_ends_seen++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result h=%0d v=%0d c=%0d end=%0b", $realtime,
                   got.half_h, got.half_v, got.half_c, got.row_end);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch: expected h=%0d v=%0d c=%0d end=%0b, %s",
                   $realtime, want.half_h, want.half_v, want.half_c, want.row_end,
                   $sformatf("got h=%0d v=%0d c=%0d end=%0b",
                             got.half_h, got.half_v, got.half_c, got.row_end));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_row_width;
  logic        in_valid;
  logic        in_stall;
  column_t     in_col;
  logic        out_valid;
  logic        out_stall;
  pix_t        out_half_h;
  pix_t        out_half_v;
  pix_t        out_half_c;
  logic        out_row_end;

  half_pel_scoreboard sb = new();

  int unsigned columns_sent;
  int unsigned width_writes;
  bit          sender_burst;
  bit          sink_burst;

  half_pel_interpolation_filter DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_row_width (cfg_row_width),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pix_up3    (in_col[0]),
    .in_pix_up2    (in_col[1]),
    .in_pix_up1    (in_col[2]),
    .in_pix_here   (in_col[3]),
    .in_pix_dn1    (in_col[4]),
    .in_pix_dn2    (in_col[5]),
    .in_pix_dn3    (in_col[6]),
    .in_pix_dn4    (in_col[7]),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_half_h    (out_half_h),
    .out_half_v    (out_half_v),
    .out_half_c    (out_half_c),
    .out_row_end   (out_row_end)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // called right after a falling edge, returns right after one
  task automatic send_column(input column_t col);
    int unsigned gap;
    gap = sender_burst ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_col = col;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_column(col);
    columns_sent++;
    if ($urandom_range(31, 0) == 0) sender_burst = ~sender_burst;
    @(negedge clk);
  endtask

  // hold off the sender until the pipeline is empty
  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_row_width(input logic [12:0] value);
    drain_pipeline();
    cfg_row_width = value;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_width(value);
    width_writes++;
  endtask

  function automatic column_t random_column();
    column_t col;
    int unsigned pick;
    foreach (col[i]) begin
      pick = $urandom_range(7, 0);
      if (pick == 0) col[i] = '0;
      else if (pick == 1) col[i] = '1;
      else col[i] = pix_t'($urandom_range(255, 0));
    end
    return col;
  endfunction

  function automatic column_t mask_column(input logic [7:0] mask);
    column_t col;
    foreach (col[i]) col[i] = mask[i] ? 8'hFF : 8'h00;
    return col;
  endfunction

  // stalls before each result unless sink_burst is set, so gaps land on every pipeline phase
  initial begin
    half_pel_t   got;
    int unsigned hold;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = sink_burst ? 0 : $urandom_range(14, 0);
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got.half_h = out_half_h;
      got.half_v = out_half_v;
      got.half_c = out_half_c;
      got.row_end = out_row_end;
      sb.check_result(got);
      if ($urandom_range(39, 0) == 0) sink_burst = ~sink_burst;
      @(negedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [7:0]  pattern[16];
    logic [12:0] fixed_widths[4];
    logic [12:0] new_width;
    int unsigned eff;
    int unsigned count;
    int unsigned phase;
    int unsigned pick;
    int unsigned waited;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_row_width = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    foreach (in_col[i]) in_col[i] = '0;
    columns_sent = 0;
    width_writes = 0;
    sender_burst = 1'b1;
    sink_burst = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // vertical and horizontal clamp to 255 on the first window, clamp to 0 on the second
    pattern = '{8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'h5A, 8'hA5, 8'h5A, 8'hA5,
                8'h5A, 8'hA5, 8'h5A, 8'hA5, 8'hA5, 8'h5A, 8'hA5, 8'h5A};
    foreach (pattern[i]) send_column(mask_column(pattern[i]));

    // zero width acts as one; the position is already past the new row end
    write_row_width(13'd0);
    repeat (9) send_column(random_column());

    fixed_widths = '{13'h1FFF, 13'd1, 13'(MAX_ROW_WIDTH), 13'd2};
    phase = 0;
    while (columns_sent < 530) begin
      if (phase < 4) begin
        new_width = fixed_widths[phase];
      end else begin
        pick = $urandom_range(99, 0);
        if (pick < 6) new_width = 13'd0;
        else if (pick < 12) new_width = 13'd1;
        else if (pick < 16) new_width = 13'(MAX_ROW_WIDTH);
        else if (pick < 20) new_width = 13'h1FFF;
        else if (pick < 26) new_width = 13'($urandom_range(8191, 0));
        else new_width = 13'($urandom_range(40, 2));
      end
      write_row_width(new_width);
      eff = sb.active_width();
      if (eff <= 64) begin
        count = $urandom_range(2, 0) * (eff + 8) + $urandom_range(eff + 7, 0);
        if (count > 140) count = 140;
        if (count == 0) count = 1;
      end else begin
        count = $urandom_range(40, 5);
      end
      sender_burst = $urandom_range(3, 0) == 0;
      sink_burst = $urandom_range(3, 0) == 0;
      repeat (count) send_column(random_column());
      phase++;
    end

    in_valid = 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors += sb.pending.size();
      $display("%0d expected results never arrived", sb.pending.size());
    end

    $display("fed %0d columns over %0d row width settings", columns_sent, width_writes + 1);
    $display("checked %0d half-pel results, %0d of them row ends", sb.results_seen,
             sb.row_ends_seen);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/hpi_pkg.sv
rtl/core/half_pel_interpolation_filter.sv
verif/tb.sv
